[rtl/rtcu_pkg.sv]
// rtcu_pkg: types, constants and calendar helpers shared by the rtc to unix time block
// no dependencies
package rtcu_pkg;

  localparam int QUEUE_DEPTH   = 2;
  localparam int APB_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;
  localparam int YEAR_W        = 12;
  localparam int FULL_W        = 13;
  localparam int CENT_W        = 6;
  localparam int DAYS_W        = 20;
  localparam int HRS_W         = 25;
  localparam int MINS_W        = 31;
  localparam int SECS_W        = 37;
  localparam int UNIX_W        = 33;

  localparam logic [YEAR_W-1:0] BASE_YEAR_RST = 12'd1970;
  localparam logic [CENT_W-1:0] BASE_CENT_RST = 6'd19;
  localparam logic [6:0]        BASE_MOD_RST  = 7'd70;

  typedef enum logic [1:0] {
    REG_BINARY_MODE = 2'd0,
    REG_TWELVE_HOUR = 2'd1,
    REG_BASE_YEAR   = 2'd2
  } reg_idx_t;

  // settings seen by the front end, with the year split into century and remainder
  typedef struct packed {
    logic              binary_mode;
    logic              twelve_hour_mode;
    logic [CENT_W-1:0] base_cent;
    logic [6:0]        base_mod;
  } cfg_t;

  // one classified snapshot waiting for the back end
  typedef struct packed {
    logic              bad;
    logic [FULL_W-1:0] full_year;
    logic [CENT_W-1:0] prev_cent;   // (full_year - 1) / 100
    logic              leap;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } item_t;

  function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic binary);
    logic [7:0] bcd;
    bcd = {4'd0, b[3:0]} + 8'(b[7:4]) * 8'd10;
    return binary ? b : bcd;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                   r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/rtc_fields_to_unix_time.sv]
// rtc_fields_to_unix_time: top level, apb registers, front end, queue and back end
// depends on rtcu_pkg, rtcu_regs, rtcu_front, rtcu_queue, rtcu_back
//
// Converts one snapshot of raw rtc bytes (bcd or binary, 12 or 24 hour) into seconds
// since 1970. A word is taken at every clock edge where start is high and busy is low;
// busy is only high during reset, so one snapshot per cycle is sustained. Each result
// appears on unix_seconds and invalid with a one-cycle done pulse, in input order. The
// word is registered in the queue at the accepting edge, then passes five back-end
// register stages (year-times-365 multiply, day sum, then the times-24 and two times-60
// multiplies); done is registered with the result in the last stage. The receiver
// cannot hold results off. On a field out of range, invalid is high and unix_seconds is
// zero. Registers must be written only while no conversion is in flight; the block
// itself does not enforce this.
module rtc_fields_to_unix_time #(
  parameter int QUEUE_DEPTH = rtcu_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtcu_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rtcu_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rtcu_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       second_raw,
  input  logic [7:0]                       minute_raw,
  input  logic [7:0]                       hour_raw,
  input  logic [7:0]                       day_raw,
  input  logic [7:0]                       month_raw,
  input  logic [7:0]                       year_raw,
  output logic                             done,
  output logic [rtcu_pkg::UNIX_W-1:0]      unix_seconds,
  output logic                             invalid
);
  import rtcu_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push;
  logic  head_valid;
  logic  q_full;

  assign busy = rst || q_full;

  rtcu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtcu_front u_front (
    .start      (start && !rst),
    .full       (q_full),
    .second_raw (second_raw),
    .minute_raw (minute_raw),
    .hour_raw   (hour_raw),
    .day_raw    (day_raw),
    .month_raw  (month_raw),
    .year_raw   (year_raw),
    .cfg        (cfg),
    .push       (push),
    .item       (push_item)
  );

  rtcu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (head_valid),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  rtcu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (head_valid),
    .in_item      (head),
    .done         (done),
    .unix_seconds (unix_seconds),
    .invalid      (invalid)
  );

  // every accepted word yields one done pulse, and done is never high without one
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, 6))
    else $error("result strobe does not match accepted word six cycles earlier");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> unix_seconds == '0)
    else $error("invalid result carries a nonzero timestamp");

endmodule

[rtl/rtcu_regs.sv]
// rtcu_regs: apb register file for mode bits and base year
// depends on rtcu_pkg
module rtcu_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtcu_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rtcu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rtcu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output rtcu_pkg::cfg_t                     cfg
);
  import rtcu_pkg::*;

  logic              binary_mode;
  logic              twelve_hour_mode;
  logic [YEAR_W-1:0] base_year;
  logic [CENT_W-1:0] base_cent;
  logic [6:0]        base_mod;
  logic              wr;
  reg_idx_t          idx;
  logic [24:0]       cent_prod;
  logic [CENT_W-1:0] cent_new;
  logic [YEAR_W-1:0] mod_wide;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // year / 100 by reciprocal, exact below 4096
  assign cent_prod = {13'd0, pwdata[YEAR_W-1:0]} * 25'd5243;
  assign cent_new  = cent_prod[24:19];
  assign mod_wide  = pwdata[YEAR_W-1:0] - YEAR_W'(cent_new) * 12'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode      <= 1'b0;
      twelve_hour_mode <= 1'b0;
      base_year        <= BASE_YEAR_RST;
      base_cent        <= BASE_CENT_RST;
      base_mod         <= BASE_MOD_RST;
    end else if (wr) begin
      unique case (idx)
        REG_BINARY_MODE: binary_mode <= pwdata[0];
        REG_TWELVE_HOUR: twelve_hour_mode <= pwdata[0];
        REG_BASE_YEAR: begin
          base_year <= pwdata[YEAR_W-1:0];
          base_cent <= cent_new;
          base_mod  <= mod_wide[6:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BINARY_MODE: prdata = {31'd0, binary_mode};
      REG_TWELVE_HOUR: prdata = {31'd0, twelve_hour_mode};
      REG_BASE_YEAR:   prdata = {20'd0, base_year};
      default:         prdata = '0;
    endcase
  end

  assign cfg.binary_mode      = binary_mode;
  assign cfg.twelve_hour_mode = twelve_hour_mode;
  assign cfg.base_cent        = base_cent;
  assign cfg.base_mod         = base_mod;

  a_year_split: assert property (@(posedge clk) disable iff (rst)
    (base_mod < 7'd100) &&
    (YEAR_W'(base_cent) * 12'd100 + YEAR_W'(base_mod) == base_year))
    else $error("base year split into century and remainder is wrong");

endmodule

[rtl/rtcu_front.sv]
// rtcu_front: decodes one raw snapshot, checks ranges and windows the year
// depends on rtcu_pkg
module rtcu_front (
  input  logic            start,
  input  logic            full,
  input  logic [7:0]      second_raw,
  input  logic [7:0]      minute_raw,
  input  logic [7:0]      hour_raw,
  input  logic [7:0]      day_raw,
  input  logic [7:0]      month_raw,
  input  logic [7:0]      year_raw,
  input  rtcu_pkg::cfg_t  cfg,
  output logic            push,
  output rtcu_pkg::item_t item
);
  import rtcu_pkg::*;

  logic [7:0]        sec;
  logic [7:0]        min;
  logic [7:0]        day;
  logic [7:0]        mon;
  logic [7:0]        yr;
  logic [7:0]        h_in;
  logic [7:0]        h_dec;
  logic [7:0]        hour;
  logic              bad_hour;
  logic              pm;
  logic [CENT_W-1:0] cent_eff;
  logic [FULL_W-1:0] full_year;
  logic              leap;
  logic              mon_ok;
  logic [4:0]        dim;
  logic              day_bad;

  assign push = start && !full;

  assign sec  = decode_byte(second_raw, cfg.binary_mode);
  assign min  = decode_byte(minute_raw, cfg.binary_mode);
  assign day  = decode_byte(day_raw, cfg.binary_mode);
  assign mon  = decode_byte(month_raw, cfg.binary_mode);
  assign yr   = decode_byte(year_raw, cfg.binary_mode);
  assign pm   = hour_raw[7];
  assign h_in = cfg.twelve_hour_mode ? {1'b0, hour_raw[6:0]} : hour_raw;
  assign h_dec = decode_byte(h_in, cfg.binary_mode);

  always_comb begin
    if (cfg.twelve_hour_mode) begin
      bad_hour = (h_dec < 8'd1) || (h_dec > 8'd12);
      if (h_dec == 8'd12) begin
        hour = pm ? 8'd12 : 8'd0;
      end else begin
        hour = pm ? h_dec + 8'd12 : h_dec;
      end
    end else begin
      bad_hour = h_dec > 8'd23;
      hour     = h_dec;
    end
  end

  // two-digit window: below the base remainder means next century
  assign cent_eff  = (yr >= {1'b0, cfg.base_mod}) ? cfg.base_cent : cfg.base_cent + 6'd1;
  assign full_year = FULL_W'(cent_eff) * 13'd100 + FULL_W'(yr);

  // with yr in 0..99, full_year % 100 is yr and full_year / 100 is cent_eff
  assign leap    = (yr == 8'd0) ? (cent_eff[1:0] == 2'b00) : (yr[1:0] == 2'b00);
  assign mon_ok  = (mon >= 8'd1) && (mon <= 8'd12);
  assign dim     = month_len(mon[3:0]) + 5'((mon == 8'd2) && leap);
  assign day_bad = (day == 8'd0) || (day > {3'd0, dim});

  always_comb begin
    item.bad = bad_hour || (sec > 8'd59) || (min > 8'd59) || (yr > 8'd99) || !mon_ok ||
               (full_year < 13'd1970) || day_bad;
    item.full_year = full_year;
    item.prev_cent = (yr == 8'd0) ? cent_eff - 6'd1 : cent_eff;
    item.leap      = leap;
    item.month     = mon[3:0];
    item.day       = day[4:0];
    item.hour      = hour[4:0];
    item.minute    = min[5:0];
    item.second    = sec[5:0];
  end

endmodule

[rtl/rtcu_queue.sv]
// rtcu_queue: short word queue between the front and back ends
// depends on rtcu_pkg
module rtcu_queue #(
  parameter int DEPTH = rtcu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtcu_pkg::item_t push_item,
  input  logic            pop,
  output rtcu_pkg::item_t head,
  output logic            head_valid,
  output logic            full
);
  import rtcu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == CW'(DEPTH);

  always_comb begin
    count_next = count;
    if (push && !(pop && head_valid)) begin
      count_next = count + 1'b1;
    end else if (!push && pop && head_valid) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop && head_valid) begin
        rd_ptr <= bump(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // the back end drains every cycle, so at most one word ever waits
  a_shallow: assert property (@(posedge clk) disable iff (rst) count <= CW'(1))
    else $error("queue holds more than one word");

endmodule

[rtl/rtcu_back.sv]
// rtcu_back: day count and seconds pipeline, five register stages
// depends on rtcu_pkg
module rtcu_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  rtcu_pkg::item_t               in_item,
  output logic                          done,
  output logic [rtcu_pkg::UNIX_W-1:0]   unix_seconds,
  output logic                          invalid
);
  import rtcu_pkg::*;

  // stage valids and bad flags
  logic [3:0]        v;
  logic [3:0]        bad;
  logic [4:0]        hour1, hour2;
  logic [5:0]        min1, min2, min3;
  logic [5:0]        sec1, sec2, sec3, sec4;
  logic [DAYS_W-1:0] yd1, ld1;
  logic [DAYS_W-1:0] days2;
  logic [HRS_W-1:0]  hrs3;
  logic [MINS_W-1:0] mins4;

  logic [FULL_W-1:0] yoff;
  logic [FULL_W-1:0] fm1;
  logic [21:0]       yprod;
  logic [DAYS_W-1:0] ld_next;
  logic [SECS_W-1:0] secs;

  assign yoff  = in_item.full_year - 13'd1970;
  assign fm1   = in_item.full_year - 13'd1;
  assign yprod = {9'd0, yoff} * 22'd365;

  // leap days since 1970 plus day of year; the constant folds the 1969 counts
  assign ld_next = DAYS_W'(fm1 >> 2) - DAYS_W'(in_item.prev_cent)
                 + DAYS_W'(in_item.prev_cent >> 2) - 20'd477
                 + DAYS_W'(month_start(in_item.month))
                 + DAYS_W'(in_item.leap && (in_item.month > 4'd2))
                 + DAYS_W'(in_item.day) - 20'd1;

  assign secs = {6'd0, mins4} * 37'd60 + SECS_W'(sec4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[2:0], in_valid};
      done <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    bad[0] <= in_item.bad;
    yd1    <= yprod[DAYS_W-1:0];
    ld1    <= ld_next;
    hour1  <= in_item.hour;
    min1   <= in_item.minute;
    sec1   <= in_item.second;

    bad[1] <= bad[0];
    days2  <= yd1 + ld1;
    hour2  <= hour1;
    min2   <= min1;
    sec2   <= sec1;

    bad[2] <= bad[1];
    hrs3   <= {5'd0, days2} * 25'd24 + HRS_W'(hour2);
    min3   <= min2;
    sec3   <= sec2;

    bad[3] <= bad[2];
    mins4  <= {6'd0, hrs3} * 31'd60 + MINS_W'(min3);
    sec4   <= sec3;

    // anything past 33 bits is out of range too
    if (bad[3] || (secs[SECS_W-1:UNIX_W] != '0)) begin
      unix_seconds <= '0;
      invalid      <= 1'b1;
    end else begin
      unix_seconds <= secs[UNIX_W-1:0];
      invalid      <= 1'b0;
    end
  end

endmodule
